// ----- rtl/tgrp_pkg.sv -----
// ----------------------------------------------------------------------------
// tgrp_pkg
// Shared types and constants for the nine-dot glyph row packer: transaction
// payloads, operation codes and parameter defaults.
// ----------------------------------------------------------------------------
package tgrp_pkg;

   // Parameter defaults
   localparam int GLYPH_ROWS_DEF       = 14;
   localparam int CHAR_CODES_DEF       = 256;
   localparam int SCREEN_SCANLINES_DEF = 348;

   // Fixed screen geometry
   localparam int TEXT_COLUMNS = 80;

   // Operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   // Request transaction
   typedef struct packed {
      logic       op;
      logic [7:0] char_code;
      logic [3:0] glyph_row;
      logic [7:0] font_byte;
      logic [4:0] text_line;
      logic [6:0] column;
   } req_type;

   // Response transaction: one packed output byte
   typedef struct packed {
      logic [1:0] field_sel;
      logic [6:0] field_row;
      logic [6:0] byte_col;
      logic [7:0] pixels;
      logic       last;
   } rsp_type;

endpackage

// ----- rtl/text_glyph_row_packer_9dot_top.sv -----
// ----------------------------------------------------------------------------
// text_glyph_row_packer_9dot_top
// Nine-dot text character generator: glyph store, 9-dot cell packing and
// interleaved field addressing for a four-way interleaved bitmap.
// ----------------------------------------------------------------------------
// Usage: the block takes one request per clock unless the output stalls or a
// second byte is pending. A load writes one byte of the glyph store and returns
// nothing. A render is looked up in the glyph store (synchronous read at the
// accepting edge) and its first output byte moves from the read and stage
// registers to the output register when free. A render whose column mod 8 is
// 7 finishes a group of eight cells and yields two bytes; the second waits in
// a pending register, follows the first and holds back the next cell. Renders
// with a bad glyph row, a column past 79 or a scanline past the screen are
// dropped with no response. Cells of one scanline must arrive in column order;
// glyph bytes read before being loaded are undefined.
// ----------------------------------------------------------------------------
module text_glyph_row_packer_9dot_top #(
   parameter int GLYPH_ROWS       = tgrp_pkg::GLYPH_ROWS_DEF,
   parameter int CHAR_CODES       = tgrp_pkg::CHAR_CODES_DEF,
   parameter int SCREEN_SCANLINES = tgrp_pkg::SCREEN_SCANLINES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tgrp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tgrp_pkg::rsp_type rsp_data
);
   import tgrp_pkg::*;

   localparam int Depth  = CHAR_CODES * GLYPH_ROWS;
   localparam int AddrW  = $clog2(Depth);
   localparam int ScanW  = $clog2(31 * GLYPH_ROWS + 16);

   // Render stage between the glyph read and the output register
   typedef struct packed {
      logic [1:0] field_sel;
      logic [6:0] field_row;
      logic [6:0] byte_col;
      logic [2:0] held;
   } stage_type;

   // Glyph store and read data
   logic [7:0]      glyph_store_ff [Depth];
   logic [7:0]      glyph_rd_ff;

   logic            s1_valid_ff, s1_valid_in;
   stage_type       s1_ff, s1_in;
   logic [7:0]      carry_ff, carry_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;
   logic            pend_valid_ff, pend_valid_in;
   rsp_type         pend_ff, pend_in;

   logic            req_acc, load_we, render_ok;
   logic [7:0]      code_wrap;
   logic [AddrW-1:0] addr;
   logic [ScanW-1:0] scan;
   logic            row_ok, code_ok, col_ok, scan_ok;

   logic            out_free, s1_move, two_bytes;
   logic [15:0]     comb;
   logic [15:0]     comb_shift;
   logic [7:0]      carry_mask;
   logic [7:0]      keep_mask;
   rsp_type         first_rsp, second_rsp;

   // Decode the incoming request
   always_comb begin
      req_acc   = req_valid && req_ready;
      row_ok    = {1'b0, req_data.glyph_row} < 5'(GLYPH_ROWS);
      code_ok   = {1'b0, req_data.char_code} < 9'(CHAR_CODES);
      col_ok    = req_data.column < 7'(TEXT_COLUMNS);
      scan      = ScanW'(int'(req_data.text_line) * GLYPH_ROWS + int'(req_data.glyph_row));
      scan_ok   = {1'b0, scan} < (ScanW + 1)'(SCREEN_SCANLINES);
      code_wrap = code_ok ? req_data.char_code
                          : 8'({1'b0, req_data.char_code} - 9'(CHAR_CODES));
      addr      = AddrW'(int'(code_wrap) * GLYPH_ROWS + int'(req_data.glyph_row));
      load_we   = req_acc && (req_data.op == OP_LOAD) && code_ok && row_ok;
      render_ok = req_acc && (req_data.op == OP_RENDER) && row_ok && col_ok && scan_ok;
   end

   // Write loads, read renders
   always_ff @(posedge clock) begin
      if (load_we) begin
         glyph_store_ff[addr] <= req_data.font_byte;
      end
      if (render_ok) begin
         glyph_rd_ff <= glyph_store_ff[addr];
      end
   end

   // Capture the cell address fields alongside the read
   always_comb begin
      s1_in.field_sel = scan[1:0];
      s1_in.field_row = 7'(scan >> 2);
      s1_in.byte_col  = req_data.column + 7'(req_data.column >> 3);
      s1_in.held      = req_data.column[2:0];
   end

   // Pack the cell with the carried dots
   always_comb begin
      carry_mask = 8'((9'd1 << s1_ff.held) - 9'd1);
      comb       = {7'(carry_ff & carry_mask), 9'(glyph_rd_ff)};
      two_bytes  = (s1_ff.held == 3'd7);
      comb_shift = comb >> (5'(s1_ff.held) + 5'd1);
      keep_mask  = 8'((9'd1 << (4'(s1_ff.held) + 4'd1)) - 9'd1);

      first_rsp.field_sel  = s1_ff.field_sel;
      first_rsp.field_row  = s1_ff.field_row;
      first_rsp.byte_col   = s1_ff.byte_col;
      first_rsp.pixels     = two_bytes ? comb[15:8] : comb_shift[7:0];
      first_rsp.last       = !two_bytes;

      second_rsp.field_sel = s1_ff.field_sel;
      second_rsp.field_row = s1_ff.field_row;
      second_rsp.byte_col  = s1_ff.byte_col + 7'd1;
      second_rsp.pixels    = comb[7:0];
      second_rsp.last      = 1'b1;
   end

   // Advance the pipeline and steer the output register
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      s1_move   = s1_valid_ff && out_free && !pend_valid_ff;
      req_ready = !s1_valid_ff || s1_move;

      s1_valid_in = render_ok ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

      carry_in = carry_ff;
      if (s1_move) begin
         carry_in = two_bytes ? 8'd0 : (comb[7:0] & keep_mask);
      end

      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (out_free) begin
         priority if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = pend_ff;
            pend_valid_in = 1'b0;
         end else if (s1_move) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = first_rsp;
            pend_valid_in = two_bytes;
            pend_in       = second_rsp;
         end else begin
            rsp_valid_in  = 1'b0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         carry_ff      <= 8'd0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         carry_ff      <= carry_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (render_ok) begin
         s1_ff <= s1_in;
      end
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
